FILE: hdl/rgcs_pkg.sv
// Shared types, sizes and register indexes for the rectangle grid scatter unit.
// No dependencies; imported by rect_grid_cell_scatter_unit.
package rgcs_pkg;

    localparam int MAX_SIDE    = 8;
    localparam int COUNT_WIDTH = 16;

    localparam int COORD_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int EPS_W      = 8;
    localparam int SIDE_REG_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int ID_W       = 6;
    localparam int SLOT_W     = 16;
    localparam int NUM_CORNER = 4;
    localparam int CORNER_W   = 2;

    localparam int CELLS   = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int V_W     = COORD_W + 1;
    localparam int PROD_W  = V_W + SIDE_REG_W;
    localparam int HI_W    = PROD_W - FRAC_W;

    localparam int S_TDATA_W = ((NUM_CORNER * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + SLOT_W + 1 + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 1'd1;

    localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 4'd8;
    localparam logic [EPS_W-1:0]      EPS_RESET  = 8'd1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

FILE: hdl/rect_grid_cell_scatter_unit.sv
// Rectangle grid scatter unit: maps rectangles onto grid cells and counts per-cell fills.
// Depends on rgcs_pkg for sizes, register indexes and the sequencer state type.
//
// A request with tuser set clears every cell counter and completes on acceptance
// with no result. A place request is accepted, then a corner pass in which one
// shared multiplier turns the four corners into cell indexes, then for each
// covered cell a counter read, then a counter update and result; the update
// waits while the result side stalls. The input is not ready while a
// rectangle is in work. The per-cell counters sit in a memory with one read and one
// write port and a valid bit per entry, so reset and clear take effect at once with
// no clearing pass.
module rect_grid_cell_scatter_unit
    import rgcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // min_x, min_y, max_x, max_y from bit 0 up, zero fill to the top.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind.
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cell_id, slot, overflow from bit 0 up, zero fill to the top.
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast
);

    state_t state_reg, state_next;

    logic [SIDE_REG_W-1:0]  side_reg, side_next;
    logic [EPS_W-1:0]       eps_reg, eps_next;
    logic [SIDE_REG_W-1:0]  n_reg, n_next;
    logic [CORNER_W-1:0]    idx_reg, idx_next;
    logic [COORD_W-1:0]     coord_reg [NUM_CORNER];
    logic [COORD_W-1:0]     coord_next [NUM_CORNER];
    logic [CELL_W-1:0]      bound_reg [NUM_CORNER];
    logic [CELL_W-1:0]      bound_next [NUM_CORNER];
    logic [CELL_W-1:0]      x_reg, x_next;
    logic [CELL_W-1:0]      y_reg, y_next;
    logic [ADDR_W-1:0]      id_reg, id_next;
    logic [CELLS-1:0]       valid_reg, valid_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic                   out_ovf_reg, out_ovf_next;
    logic                   out_last_reg, out_last_next;

    logic [COUNT_WIDTH-1:0] mem [CELLS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;

    logic                   in_accept;
    logic                   out_ready;
    logic [SIDE_REG_W-1:0]  eff_side;
    logic [V_W-1:0]         mul_a;
    logic [PROD_W-1:0]      prod;
    logic [HI_W-1:0]        cell_hi;
    logic [SIDE_REG_W-1:0]  n_m1;
    logic [CELL_W-1:0]      cell_val;
    logic [ADDR_W-1:0]      rd_addr;
    logic [COUNT_WIDTH-1:0] cur;
    logic                   cur_ovf;
    logic                   is_last;
    logic                   mem_we;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_ready = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_W'({out_ovf_reg, out_slot_reg, out_id_reg});

    always_comb begin
        if (side_reg == '0) begin
            eff_side = SIDE_REG_W'(1);
        end else if (side_reg > SIDE_REG_W'(MAX_SIDE)) begin
            eff_side = SIDE_REG_W'(MAX_SIDE);
        end else begin
            eff_side = side_reg;
        end
    end

    // The shared multiplier scales a biased corner in the corner pass and
    // forms the row offset y * n in the counter read cycle.
    always_comb begin
        if (state_reg == ST_CALC) begin
            mul_a = V_W'(coord_reg[idx_reg]) + V_W'(eps_reg);
        end else begin
            mul_a = V_W'(y_reg);
        end
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(n_reg);
    assign cell_hi = prod[PROD_W-1:FRAC_W];
    assign n_m1    = n_reg - SIDE_REG_W'(1);
    assign cell_val = (cell_hi > HI_W'(n_m1)) ? CELL_W'(n_m1) : CELL_W'(cell_hi);
    assign rd_addr = ADDR_W'(prod) + ADDR_W'(x_reg);

    assign cur     = rd_valid_reg ? rd_data_reg : '0;
    assign cur_ovf = (cur == COUNT_MAX);
    assign is_last = (x_reg == bound_reg[2]) && (y_reg == bound_reg[3]);
    assign mem_we  = (state_reg == ST_EMIT) && out_ready && !cur_ovf;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && !s_tuser) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (idx_reg == CORNER_W'(NUM_CORNER - 1)) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_ready) begin
                    state_next = is_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        side_next     = side_reg;
        eps_next      = eps_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        coord_next    = coord_reg;
        bound_next    = bound_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        id_next       = id_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_id_next   = out_id_reg;
        out_slot_next = out_slot_reg;
        out_ovf_next  = out_ovf_reg;
        out_last_next = out_last_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_SIDE: side_next = SIDE_REG_W'(cfg_wdata);
                REG_EPSILON:   eps_next  = EPS_W'(cfg_wdata);
                default:       side_next = side_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser) begin
                        valid_next = '0;
                    end else begin
                        for (int i = 0; i < NUM_CORNER; i++) begin
                            coord_next[i] = s_tdata[i*COORD_W +: COORD_W];
                        end
                        n_next   = eff_side;
                        idx_next = '0;
                    end
                end
            end
            ST_CALC: begin
                idx_next = idx_reg + CORNER_W'(1);
                bound_next[idx_reg] = cell_val;
                // An inverted axis covers its start cell only.
                if (idx_reg >= CORNER_W'(2)) begin
                    if (cell_val < bound_reg[idx_reg - CORNER_W'(2)]) begin
                        bound_next[idx_reg] = bound_reg[idx_reg - CORNER_W'(2)];
                    end
                end
                if (idx_reg == CORNER_W'(NUM_CORNER - 1)) begin
                    x_next = bound_reg[0];
                    y_next = bound_reg[1];
                end
            end
            ST_READ: begin
                id_next = rd_addr;
            end
            ST_EMIT: begin
                if (out_ready) begin
                    m_tvalid_next = 1'b1;
                    out_id_next   = ID_W'(id_reg);
                    out_slot_next = SLOT_W'(cur);
                    out_ovf_next  = cur_ovf;
                    out_last_next = is_last;
                    if (mem_we) begin
                        valid_next[id_reg] = 1'b1;
                    end
                    if (y_reg == bound_reg[3]) begin
                        y_next = bound_reg[1];
                        x_next = x_reg + CELL_W'(1);
                    end else begin
                        y_next = y_reg + CELL_W'(1);
                    end
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            side_reg     <= SIDE_RESET;
            eps_reg      <= EPS_RESET;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            side_reg     <= side_next;
            eps_reg      <= eps_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        coord_reg    <= coord_next;
        bound_reg    <= bound_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        id_reg       <= id_next;
        out_id_reg   <= out_id_next;
        out_slot_reg <= out_slot_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[id_reg] <= cur + COUNT_WIDTH'(1);
        end
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_ready && is_last) |=> (state_reg == ST_IDLE))
        else $error("Sequencer did not return to idle after the last cell.");

    a_walk_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (x_reg >= bound_reg[0] && x_reg <= bound_reg[2]
            && y_reg >= bound_reg[1] && y_reg <= bound_reg[3]))
        else $error("Cell walk left the rectangle bounds.");

    a_addr_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (32'(rd_addr) < 32'(n_reg) * 32'(n_reg)))
        else $error("Counter address outside the active grid.");

    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_ready) |=> m_tvalid_reg)
        else $error("Cell update did not produce a result.");

endmodule

FILE: bench/tb_rect_grid_cell_scatter_unit.sv
// Self-checking bench for rect_grid_cell_scatter_unit: a table of directed requests, random
// requests under several idle and stall mixes, and a short tail of full-grid, clear and single-cell requests.
// Depends on rgcs_pkg and the unit itself; every result is checked against a local predictor.
`timescale 1ns / 100ps

module tb_rect_grid_cell_scatter_unit;
    import rgcs_pkg::*;

    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   DRAIN_CYCLES  = 150;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   PHASE_ITEMS   = 80;
    localparam int   NUM_ROWS      = 25;
    localparam int   GAP_BY_PHASE   [4] = '{0, 59, 0, 21};
    localparam int   STALL_BY_PHASE [4] = '{0, 0, 59, 21};

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
    } rect_req_t;

    typedef struct packed {
        logic [ID_W-1:0]   cell_id;
        logic [SLOT_W-1:0] slot;
        logic              overflow;
        logic              last;
    } cell_hit_t;

    typedef enum logic [1:0] {
        ROW_PLACE,
        ROW_CLEAR,
        ROW_SIDE,
        ROW_EPS
    } row_op_t;

    typedef struct packed {
        row_op_t               op;
        logic [COORD_W-1:0]    min_x;
        logic [COORD_W-1:0]    min_y;
        logic [COORD_W-1:0]    max_x;
        logic [COORD_W-1:0]    max_y;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        logic [6:0]            n_cells;
        logic [ID_W-1:0]       cell_id;
        logic [SLOT_W-1:0]     slot;
    } dir_row_t;

    // Rows marked typed carry the result count and, for one result, its cell and slot.
    localparam dir_row_t DIRECTED [0:NUM_ROWS-1] = '{
        '{ROW_PLACE, 0, 0, 0, 0, 0, 1, 1, 0, 0},
        '{ROW_PLACE, 0, 0, 0, 0, 0, 1, 1, 0, 1},
        '{ROW_PLACE, 65536, 65536, 65536, 65536, 0, 1, 1, 63, 0},
        '{ROW_PLACE, 131071, 131071, 131071, 131071, 0, 1, 1, 63, 1},
        '{ROW_PLACE, 0, 0, 65536, 65536, 0, 0, 0, 0, 0},
        '{ROW_PLACE, 60000, 60000, 0, 0, 0, 1, 1, 63, 3},
        '{ROW_PLACE, 40000, 0, 10000, 20000, 0, 0, 0, 0, 0},
        '{ROW_CLEAR, 131071, 0, 131071, 0, 0, 1, 0, 0, 0},
        '{ROW_PLACE, 0, 0, 0, 0, 0, 1, 1, 0, 0},
        '{ROW_PLACE, 10000, 20000, 30000, 45000, 0, 0, 0, 0, 0},
        '{ROW_PLACE, 8191, 0, 8191, 0, 0, 1, 1, 1, 0},
        '{ROW_PLACE, 8190, 0, 8190, 0, 0, 1, 1, 0, 1},
        '{ROW_SIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_PLACE, 65536, 65536, 131071, 131071, 0, 1, 1, 0, 2},
        '{ROW_SIDE, 0, 0, 0, 0, 255, 0, 0, 0, 0},
        '{ROW_EPS, 0, 0, 0, 0, 255, 0, 0, 0, 0},
        '{ROW_PLACE, 0, 0, 0, 0, 0, 1, 1, 0, 3},
        '{ROW_PLACE, 65281, 0, 65281, 0, 0, 1, 1, 7, 0},
        '{ROW_SIDE, 0, 0, 0, 0, 3, 0, 0, 0, 0},
        '{ROW_EPS, 0, 0, 0, 0, 128, 0, 0, 0, 0},
        '{ROW_PLACE, 0, 0, 65536, 65536, 0, 0, 0, 0, 0},
        '{ROW_PLACE, 21845, 43690, 43690, 65535, 0, 0, 0, 0, 0},
        '{ROW_SIDE, 0, 0, 0, 0, 8, 0, 0, 0, 0},
        '{ROW_EPS, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // min_x, min_y, max_x, max_y from bit 0 up, zero fill to the top.
    logic [S_TDATA_W-1:0]  s_tdata;
    // kind.
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // cell_id, slot, overflow from bit 0 up, zero fill to the top.
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    logic [SIDE_REG_W-1:0]  side_reg = SIDE_RESET;
    logic [EPS_W-1:0]       eps_reg  = EPS_RESET;
    logic [COUNT_WIDTH-1:0] cell_fill [CELLS] = '{default: '0};
    cell_hit_t              pending_cells [$];
    cell_hit_t              last_result;
    int unsigned            results_seen  = 0;
    int unsigned            mismatches    = 0;
    int unsigned            stall_pct     = 0;
    int unsigned            hold_requests = 0;
    int unsigned            holds_done    = 0;

    rect_grid_cell_scatter_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned grid_cell(input logic [COORD_W-1:0] coord,
                                              input int unsigned n);
        int unsigned c;
        c = ((32'(coord) + 32'(eps_reg)) * n) >> FRAC_W;
        return (c > n - 1) ? n - 1 : c;
    endfunction

    // Walks the covered cells column by column and queues one hit per cell.
    function automatic void scatter_rect(input logic kind, input logic [S_TDATA_W-1:0] data);
        int unsigned n, xs, ys, xe, ye, x, y, id;
        logic [COUNT_WIDTH-1:0] cur;
        cell_hit_t hit;
        if (kind == KIND_CLEAR) begin
            cell_fill = '{default: '0};
            return;
        end
        n  = (side_reg == 0) ? 1 : (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
        xs = grid_cell(data[0 +: COORD_W], n);
        ys = grid_cell(data[COORD_W +: COORD_W], n);
        xe = grid_cell(data[2*COORD_W +: COORD_W], n);
        ye = grid_cell(data[3*COORD_W +: COORD_W], n);
        if (xe < xs) xe = xs;
        if (ye < ys) ye = ys;
        for (x = xs; x <= xe; x++) begin
            for (y = ys; y <= ye; y++) begin
                id  = (y * n + x) % CELLS;
                cur = cell_fill[id];
                if (cur != COUNT_MAX) cell_fill[id] = cur + 1'b1;
                hit.cell_id  = ID_W'(id);
                hit.slot     = SLOT_W'(cur);
                hit.overflow = (cur == COUNT_MAX);
                hit.last     = (x == xe && y == ye);
                pending_cells = {pending_cells, hit};
            end
        end
    endfunction

    task automatic check_cell();
        cell_hit_t want;
        last_result = {m_tdata[0 +: ID_W], m_tdata[ID_W +: SLOT_W], m_tdata[ID_W + SLOT_W],
                       m_tlast};
        results_seen++;
        if (pending_cells.size() == 0) begin
            report_mismatch("result with nothing pending, cell_id", last_result.cell_id, -1);
            return;
        end
        want = pending_cells.pop_front();
        if (last_result.cell_id != want.cell_id)
            report_mismatch("cell_id", last_result.cell_id, want.cell_id);
        if (last_result.slot != want.slot)
            report_mismatch("slot", last_result.slot, want.slot);
        if (last_result.overflow != want.overflow)
            report_mismatch("overflow", last_result.overflow, want.overflow);
        if (last_result.last != want.last)
            report_mismatch("tlast", last_result.last, want.last);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) scatter_rect(s_tuser, s_tdata);
            if (m_tvalid && m_tready) check_cell();
        end
    end

    // The result side stalls at random, or holds off for a long stretch when asked.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_rect(input rect_req_t r, input int unsigned gap_pct);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {{(S_TDATA_W - NUM_CORNER * COORD_W){1'b0}},
                     r.max_y, r.max_x, r.min_y, r.min_x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // The first edge lets the monitor record the last request; a clear request
    // leaves no result behind, so the unit also gets a settle wait once nothing is pending.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_GRID_SIDE) side_reg = value[SIDE_REG_W-1:0];
        else eps_reg = value[EPS_W-1:0];
        @(posedge aclk);
    endtask

    // Mostly small rectangles, some full squares, some arbitrary corners, some clear requests.
    function automatic rect_req_t random_rect();
        rect_req_t r;
        int unsigned pick;
        pick    = $urandom_range(99);
        r.kind  = (pick < 5) ? KIND_CLEAR : KIND_PLACE;
        r.min_x = COORD_W'($urandom_range(65536));
        r.min_y = COORD_W'($urandom_range(65536));
        r.max_x = COORD_W'(32'(r.min_x) + $urandom_range(16384));
        r.max_y = COORD_W'(32'(r.min_y) + $urandom_range(16384));
        if (pick < 15) begin
            r.min_x = COORD_W'($urandom);
            r.min_y = COORD_W'($urandom);
            r.max_x = COORD_W'($urandom);
            r.max_y = COORD_W'($urandom);
        end else if (pick < 18) begin
            r.min_x = '0;
            r.min_y = '0;
            r.max_x = 17'd65536;
            r.max_y = 17'd65536;
        end
        return r;
    endfunction

    initial begin
        #100ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        rect_req_t   req;
        dir_row_t    row;
        int unsigned seen;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED[i];
            case (row.op)
                ROW_SIDE: write_reg(REG_GRID_SIDE, row.value);
                ROW_EPS:  write_reg(REG_EPSILON, row.value);
                default: begin
                    seen      = results_seen;
                    req.kind  = (row.op == ROW_CLEAR) ? KIND_CLEAR : KIND_PLACE;
                    req.min_x = row.min_x;
                    req.min_y = row.min_y;
                    req.max_x = row.max_x;
                    req.max_y = row.max_y;
                    send_rect(req, 0);
                    wait_idle();
                    if (row.typed) begin
                        if (results_seen - seen != row.n_cells) begin
                            report_mismatch("result count", results_seen - seen, row.n_cells);
                        end else if (row.n_cells == 1) begin
                            if (last_result.cell_id != row.cell_id)
                                report_mismatch("table cell_id", last_result.cell_id,
                                                row.cell_id);
                            if (last_result.slot != row.slot)
                                report_mismatch("table slot", last_result.slot, row.slot);
                            if (!last_result.last)
                                report_mismatch("table tlast", last_result.last, 1);
                        end
                    end
                end
            endcase
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(REG_GRID_SIDE, 8'd8);
                    write_reg(REG_EPSILON, 8'd0);
                end
                1: begin
                    write_reg(REG_GRID_SIDE, CFG_DATA_W'($urandom_range(1, 7)));
                    write_reg(REG_EPSILON, 8'd255);
                end
                2: begin
                    write_reg(REG_GRID_SIDE, CFG_DATA_W'($urandom_range(255)));
                    write_reg(REG_EPSILON, CFG_DATA_W'($urandom_range(255)));
                end
                default: begin
                    write_reg(REG_GRID_SIDE, CFG_DATA_W'($urandom_range(2, 8)));
                    write_reg(REG_EPSILON, CFG_DATA_W'($urandom_range(255)));
                end
            endcase
            stall_pct = STALL_BY_PHASE[ph];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == PHASE_ITEMS / 2) wait_idle();
                send_rect(random_rect(), GAP_BY_PHASE[ph]);
            end

            // Back pressure: the result side holds off while requests keep coming.
            if (ph == 0) begin
                hold_requests++;
                for (int k = 0; k < 12; k++) send_rect(random_rect(), 0);
            end
        end

        wait_idle();
        stall_pct = 0;
        write_reg(REG_GRID_SIDE, 8'd8);
        send_rect('{KIND_PLACE, 17'd0, 17'd0, 17'd65536, 17'd65536}, 0);
        send_rect('{KIND_CLEAR, 17'd0, 17'd0, 17'd0, 17'd0}, 0);
        send_rect('{KIND_PLACE, 17'd0, 17'd0, 17'd0, 17'd0}, 0);
        s_tvalid <= 1'b0;

        for (int k = 0; k < 200000 && pending_cells.size() != 0; k++) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_cells.size() != 0)
            report_mismatch("results never delivered", 0, pending_cells.size());
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
